@@ design/pof_pkg.sv @@
// ----------------------------------------------------------------------------
// pof_pkg: shared types and constants of the PE overlay offset finder
// Byte codes of the stamps, layout offsets of the headers and the result
// status codes, used by the stages and the top level.
// ----------------------------------------------------------------------------
package pof_pkg;

  // Default section limit
  localparam int unsigned MaxSectionsDef = 96;

  // Layout of the DOS and PE headers
  localparam logic [31:0] HdrPtrPos  = 32'h0000_003C;
  localparam logic [31:0] HdrMinOff  = 32'h0000_0040;
  localparam logic [5:0]  EntryLast  = 6'd39;
  localparam logic [5:0]  RawSizeLo  = 6'd16;
  localparam logic [5:0]  RawPtrHi   = 6'd23;
  localparam logic [32:0] PeFixedLen = 33'd24;

  // Offsets inside the PE header
  localparam logic [31:0] OffSig0    = 32'd0;
  localparam logic [31:0] OffSig1    = 32'd1;
  localparam logic [31:0] OffSig2    = 32'd2;
  localparam logic [31:0] OffSig3    = 32'd3;
  localparam logic [31:0] OffCntLo   = 32'd6;
  localparam logic [31:0] OffCntHi   = 32'd7;
  localparam logic [31:0] OffOptLo   = 32'd20;
  localparam logic [31:0] OffOptHi   = 32'd21;
  localparam logic [31:0] OffHdrEnd  = 32'd22;

  // Stamp characters
  localparam logic [7:0] CharM = 8'h4D;
  localparam logic [7:0] CharZ = 8'h5A;
  localparam logic [7:0] CharP = 8'h50;
  localparam logic [7:0] CharE = 8'h45;

  // Result status
  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StNoMz       = 3'd1,
    StBadHdr     = 3'd2,
    StNoPe       = 3'd3,
    StBadTable   = 3'd4,
    StNoOverlay  = 3'd5
  } pof_status_e;

  // One input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } pof_item_t;

  // One result item
  typedef struct packed {
    logic [31:0] overlay_offset;
    pof_status_e status;
  } pof_result_t;

endpackage

@@ design/pof_in_stage.sv @@
// ----------------------------------------------------------------------------
// pof_in_stage: input register
// Holds one byte item; refills in the same cycle the held item is consumed.
// ----------------------------------------------------------------------------
module pof_in_stage import pof_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pof_item_t in_item_i,
  input  logic      take_i,
  output logic      valid_o,
  output pof_item_t item_o
);

  logic      valid_q, valid_d;
  pof_item_t item_q;
  logic      load;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ design/pof_core.sv @@
// ----------------------------------------------------------------------------
// pof_core: header parser and section walker
// Updates the parse state for one byte per cycle while take_i is high and, on the final byte of
// a file, settles the length checks and forms the result.
// ----------------------------------------------------------------------------
module pof_core import pof_pkg::*; #(
  parameter int unsigned MaxSections = MaxSectionsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  pof_item_t   item_i,
  output logic        res_valid_o,
  output pof_result_t res_o
);

  localparam int unsigned EntW = $clog2(MaxSections + 1);

  // State registers
  logic [31:0]     pos_q, pos_d;
  logic            mz_q, mz_d;
  logic [31:0]     ho_q, ho_d;
  logic            sig_q, sig_d;
  logic [15:0]     cnt_q, cnt_d;
  logic [15:0]     opt_q, opt_d;
  logic [31:0]     ts_q, ts_d;
  logic [5:0]      eb_q, eb_d;
  logic [EntW-1:0] ent_q, ent_d;
  logic [55:0]     fs_q, fs_d;
  logic [31:0]     max_q, max_d;

  // State after this byte
  logic [31:0]     pos_n;
  logic            mz_n;
  logic [31:0]     ho_n;
  logic            sig_n;
  logic [15:0]     cnt_n;
  logic [15:0]     opt_n;
  logic [31:0]     ts_n;
  logic [5:0]      eb_n;
  logic [EntW-1:0] ent_n;
  logic [55:0]     fs_n;
  logic [31:0]     max_n;

  logic [7:0]  b;
  logic        active;
  logic        in_ptr;
  logic        hdr_zone;
  logic [31:0] d;
  logic [32:0] ts_sum;
  logic [15:0] opt_full;
  logic        walk;
  logic        cnt_ok_q;
  logic [63:0] field_full;
  logic [31:0] end_sum;

  assign b      = item_i.data_byte;
  assign active = (pos_q != '1);
  assign in_ptr = (pos_q[31:2] == HdrPtrPos[31:2]);
  assign hdr_zone = !in_ptr && (pos_q >= HdrMinOff) && (ho_q >= HdrMinOff) && (pos_q >= ho_q);
  assign d        = pos_q - ho_q;
  assign opt_full = {b, opt_q[7:0]};
  assign ts_sum   = {1'b0, ho_q} + PeFixedLen + {17'b0, opt_full};
  assign cnt_ok_q = (cnt_q != 16'd0) && (cnt_q <= 16'(MaxSections));
  assign walk     = active && hdr_zone && (d >= OffHdrEnd) && (pos_q >= ts_q) && cnt_ok_q &&
                    ({{(16-EntW){1'b0}}, ent_q} < cnt_q);
  assign field_full = {b, fs_q};
  assign end_sum    = field_full[63:32] + field_full[31:0];

  // Update the parse state for one byte
  always_comb begin
    pos_n = pos_q;
    mz_n  = mz_q;
    ho_n  = ho_q;
    sig_n = sig_q;
    cnt_n = cnt_q;
    opt_n = opt_q;
    ts_n  = ts_q;
    eb_n  = eb_q;
    ent_n = ent_q;
    fs_n  = fs_q;
    max_n = max_q;
    if (active) begin
      pos_n = pos_q + 32'd1;
      // DOS stamp
      if (pos_q == 32'd0) begin
        mz_n = (b == CharM);
      end else if (pos_q == 32'd1) begin
        mz_n = mz_q && (b == CharZ);
      end
      // Header offset, little endian
      if (in_ptr) begin
        unique case (pos_q[1:0])
          2'd0:    ho_n = {ho_q[31:8], b};
          2'd1:    ho_n = {ho_q[31:16], b, ho_q[7:0]};
          2'd2:    ho_n = {ho_q[31:24], b, ho_q[15:0]};
          default: ho_n = {b, ho_q[23:0]};
        endcase
      end
      // PE header fields
      if (hdr_zone) begin
        priority if (d == OffSig0) begin
          sig_n = (b == CharP);
        end else if (d == OffSig1) begin
          sig_n = sig_q && (b == CharE);
        end else if ((d == OffSig2) || (d == OffSig3)) begin
          sig_n = sig_q && (b == 8'h00);
        end else if (d == OffCntLo) begin
          cnt_n = {cnt_q[15:8], b};
        end else if (d == OffCntHi) begin
          cnt_n = {b, cnt_q[7:0]};
        end else if (d == OffOptLo) begin
          opt_n = {opt_q[15:8], b};
        end else if (d == OffOptHi) begin
          opt_n = opt_full;
          ts_n  = ts_sum[32] ? '1 : ts_sum[31:0];
        end else begin
          sig_n = sig_q;
        end
      end
      // Section entry walk
      if (walk) begin
        if ((eb_q >= RawSizeLo) && (eb_q <= RawPtrHi)) begin
          fs_n = field_full[63:8];
        end
        if ((eb_q == RawPtrHi) && (end_sum > max_q)) begin
          max_n = end_sum;
        end
        if (eb_q >= EntryLast) begin
          eb_n  = '0;
          ent_n = ent_q + EntW'(1);
        end else begin
          eb_n = eb_q + 6'd1;
        end
      end
    end
  end

  // Settle the length checks on the final byte
  logic [32:0]  len_x;
  logic [21:0]  tab_len;
  logic [32:0]  tab_end;
  logic         c_mz, c_hdr, c_sig, c_tab, c_ovl;
  pof_status_e  status;

  assign len_x   = {1'b0, pos_q} + 33'd1;
  assign tab_len = {1'b0, cnt_n, 5'b0} + {3'b0, cnt_n, 3'b0};
  assign tab_end = {1'b0, ts_n} + {11'b0, tab_len};
  assign c_mz    = (pos_q < 32'd63) || !mz_n;
  assign c_hdr   = (ho_n < HdrMinOff) || (({1'b0, ho_n} + PeFixedLen) > len_x);
  assign c_sig   = !sig_n;
  assign c_tab   = (cnt_n == 16'd0) || (cnt_n > 16'(MaxSections)) || (tab_end > len_x);
  assign c_ovl   = (max_n == 32'd0) || ({1'b0, max_n} >= len_x);

  always_comb begin
    priority if (c_mz) begin
      status = StNoMz;
    end else if (c_hdr) begin
      status = StBadHdr;
    end else if (c_sig) begin
      status = StNoPe;
    end else if (c_tab) begin
      status = StBadTable;
    end else if (c_ovl) begin
      status = StNoOverlay;
    end else begin
      status = StOk;
    end
  end

  assign res_valid_o          = take_i && item_i.last;
  assign res_o.status         = status;
  assign res_o.overlay_offset = (status == StOk) ? max_n : 32'd0;

  // Clear all state after the final byte
  always_comb begin
    if (item_i.last) begin
      pos_d = '0; mz_d = 1'b0; ho_d = '0; sig_d = 1'b0; cnt_d = '0; opt_d = '0;
      ts_d  = '0; eb_d = '0;   ent_d = '0; fs_d = '0;  max_d = '0;
    end else begin
      pos_d = pos_n; mz_d = mz_n; ho_d = ho_n; sig_d = sig_n; cnt_d = cnt_n; opt_d = opt_n;
      ts_d  = ts_n;  eb_d = eb_n; ent_d = ent_n; fs_d = fs_n; max_d = max_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      mz_q  <= 1'b0;
      ho_q  <= '0;
      sig_q <= 1'b0;
      cnt_q <= '0;
      opt_q <= '0;
      ts_q  <= '0;
      eb_q  <= '0;
      ent_q <= '0;
      fs_q  <= '0;
      max_q <= '0;
    end else if (take_i) begin
      pos_q <= pos_d;
      mz_q  <= mz_d;
      ho_q  <= ho_d;
      sig_q <= sig_d;
      cnt_q <= cnt_d;
      opt_q <= opt_d;
      ts_q  <= ts_d;
      eb_q  <= eb_d;
      ent_q <= ent_d;
      fs_q  <= fs_d;
      max_q <= max_d;
    end
  end

endmodule

@@ design/pof_out_stage.sv @@
// ----------------------------------------------------------------------------
// pof_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pof_out_stage import pof_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  pof_result_t res_i,
  output logic        slot_free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pof_result_t res_o
);

  logic        valid_q, valid_d;
  pof_result_t res_q;

  // Free when empty or when the held result leaves this cycle
  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ design/pe_overlay_offset_finder_top.sv @@
// ----------------------------------------------------------------------------
// pe_overlay_offset_finder_top: PE overlay offset finder
// Parses an executable byte stream, walks its section table and reports
// where the overlay starts, one result per file.
//
//   Port group   Dir  Payload
//   s_axis_*     in   tdata[7:0] data_byte, tlast last
//   m_axis_*     out  tdata[31:0] overlay_offset, tdata[34:32] status
//
// One byte is taken per cycle unless a final byte waits on a held result; the result of a
// file is valid in the result register in the cycle after its final byte is processed.
// The byte path is input register, parse logic, state registers; the
// result register decouples the output side.
// A final byte waits in the input register only while an earlier result
// is still held; other bytes never wait on the output side.
// Reset clears all parse state and the valid flags of both stage registers.
// ----------------------------------------------------------------------------
module pe_overlay_offset_finder_top import pof_pkg::*; #(
  parameter int unsigned MaxSections = MaxSectionsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] overlay_offset, [34:32] status, rest zero
);

  pof_item_t   in_item;
  pof_item_t   cur_item;
  logic        cur_valid;
  logic        take;
  logic        slot_free;
  logic        res_valid;
  pof_result_t res;
  pof_result_t out_res;

  assign in_item.data_byte = s_axis_tdata_i;
  assign in_item.last      = s_axis_tlast_i;

  // Consume a byte unless it is final and the result slot is busy
  assign take = cur_valid && (!cur_item.last || slot_free);

  pof_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .take_i     (take),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  pof_core #(
    .MaxSections (MaxSections)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (cur_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pof_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (out_res)
  );

  assign m_axis_tdata_o = {5'b0, out_res.status, out_res.overlay_offset};

  // Error results carry a zero offset
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_res.status != StOk)) |-> (out_res.overlay_offset == 32'd0))
    else $error("error result with nonzero offset");

  // A good result always has a nonzero offset
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_res.status == StOk)) |-> (out_res.overlay_offset != 32'd0))
    else $error("good result with zero offset");

  // A consumed final byte shows up as a result next cycle
  a_final_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cur_item.last) |=> m_axis_tvalid_o)
    else $error("final byte gave no result");

  // A final byte is never consumed onto a held result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && m_axis_tvalid_o) |-> m_axis_tready_i)
    else $error("result register overwritten");

  // A held byte that is not consumed stays held
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid && !take) |=> cur_valid)
    else $error("input item lost");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stream test of the PE overlay offset finder
// Streams executable images byte by byte into the block and checks every
// result against a scoreboard that parses the same bytes. The images are
// well-formed files with random layout, broken variants of them, truncated
// files and plain noise. Both sides idle at random, and the receiver is held
// off long enough once that final bytes back up at the input.
// ----------------------------------------------------------------------------
import pof_pkg::*;

class overlay_scoreboard;
  localparam int unsigned MinFileLen = 64;
  localparam int unsigned EntryBytes = 40;

  int unsigned max_sections;

  // Parse state of the file in flight
  bit [31:0] pos_r;
  bit        mz_seen;
  bit [31:0] hdr_off;
  bit        sig_seen;
  bit [15:0] sec_cnt;
  bit [15:0] opt_len;
  bit [31:0] tbl_start;
  bit [5:0]  ent_idx;
  bit [6:0]  ent_done;
  bit [63:0] raw_win;
  bit [31:0] end_max;

  pof_result_t offset_q[$];
  int          errors;
  int          status_hits[6];

  function new(int unsigned max_sec);
    max_sections = max_sec;
    errors = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    clear_file();
  endfunction

  function void clear_file();
    pos_r     = '0;
    mz_seen   = 1'b0;
    hdr_off   = '0;
    sig_seen  = 1'b0;
    sec_cnt   = '0;
    opt_len   = '0;
    tbl_start = '0;
    ent_idx   = '0;
    ent_done  = '0;
    raw_win   = '0;
    end_max   = '0;
  endfunction

  // Update the parse state with one byte at file position p
  function void parse_byte(bit [31:0] p, bit [7:0] b);
    bit [31:0] d;
    bit [32:0] ts;
    bit [31:0] sum;
    if (p == 0) mz_seen = (b == CharM);
    else if (p == 1) mz_seen = mz_seen && (b == CharZ);

    // Capture the header offset, little endian
    if (p >= HdrPtrPos && p < HdrPtrPos + 4) begin
      hdr_off[8*int'(p[1:0]) +: 8] = b;
      return;
    end
    if (p < HdrMinOff || hdr_off < HdrMinOff || p < hdr_off) return;

    // Signature and header fields relative to the header offset
    d = p - hdr_off;
    case (d)
      OffSig0: sig_seen = (b == CharP);
      OffSig1: sig_seen = sig_seen && (b == CharE);
      OffSig2, OffSig3: sig_seen = sig_seen && (b == 8'h00);
      OffCntLo: sec_cnt[7:0] = b;
      OffCntHi: sec_cnt[15:8] = b;
      OffOptLo: opt_len[7:0] = b;
      OffOptHi: begin
        opt_len[15:8] = b;
        ts = {1'b0, hdr_off} + PeFixedLen + {17'b0, opt_len};
        tbl_start = ts[32] ? '1 : ts[31:0];
      end
      default: ;
    endcase
    if (d < OffHdrEnd || p < tbl_start) return;

    // Walk the section table
    if (sec_cnt == 0 || sec_cnt > max_sections) return;
    if (ent_done >= sec_cnt) return;
    if (ent_idx >= RawSizeLo && ent_idx <= RawPtrHi) raw_win = {b, raw_win[63:8]};
    if (ent_idx == RawPtrHi) begin
      sum = raw_win[63:32] + raw_win[31:0];
      if (sum > end_max) end_max = sum;
    end
    if (ent_idx >= EntryLast) begin
      ent_idx = '0;
      ent_done = ent_done + 7'd1;
    end else begin
      ent_idx = ent_idx + 6'd1;
    end
  endfunction

  // Note an accepted input item; a final byte queues the expected result
  function void note_item(bit [7:0] b, bit last);
    bit [31:0]         p;
    longint unsigned   flen;
    pof_status_e       st;
    pof_result_t       res;
    p = pos_r;
    if (p != '1) begin
      parse_byte(p, b);
      pos_r = p + 32'd1;
    end
    if (!last) return;

    flen = 64'(p) + 1;
    if (flen < MinFileLen || !mz_seen) st = StNoMz;
    else if (hdr_off < HdrMinOff || 64'(hdr_off) + 64'(PeFixedLen) > flen) st = StBadHdr;
    else if (!sig_seen) st = StNoPe;
    else if (sec_cnt == 0 || sec_cnt > max_sections ||
             64'(tbl_start) + 64'(sec_cnt) * EntryBytes > flen) st = StBadTable;
    else if (end_max == 0 || 64'(end_max) >= flen) st = StNoOverlay;
    else st = StOk;

    res.status = st;
    res.overlay_offset = (st == StOk) ? end_max : '0;
    offset_q.push_back(res);
    clear_file();
  endfunction

  // Compare an accepted result with the oldest expectation
  function void check_result(bit [39:0] data);
    pof_result_t exp_r;
    bit [31:0]   got_off;
    bit [2:0]    got_st;
    got_off = data[31:0];
    got_st  = data[34:32];
    if (offset_q.size() == 0) begin
      $error("result with none expected: overlay_offset %h status %0d", got_off, got_st);
      errors++;
      return;
    end
    exp_r = offset_q.pop_front();
    status_hits[int'(exp_r.status)]++;
    if (got_st != exp_r.status) begin
      $error("status: expected %0d (%s), actual %0d", exp_r.status, exp_r.status.name(),
             got_st);
      errors++;
    end
    if (got_off != exp_r.overlay_offset) begin
      $error("overlay_offset: expected %h, actual %h", exp_r.overlay_offset, got_off);
      errors++;
    end
    if (data[39:35] != '0) begin
      $error("tdata pad: expected 0, actual %h", data[39:35]);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 6;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 400;
  localparam int ItemTarget  = 1450;
  localparam int DrainCycles = 8;

  typedef enum int {
    FileGood, FileNoMz, FileLowOff, FileFarOff, FileNoSig, FileNoSections,
    FileTooMany, FileWrapEnd, FileZeroEnd, FileEndPastLen, FileTruncated,
    FileNoise
  } file_kind_e;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  overlay_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          holdoff_req = 0;
  int          quiet_cycles = 0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  bit [7:0]    img[$];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  pe_overlay_offset_finder_top #(
    .MaxSections(MaxSectionsDef)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  // Drive the result ready: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (holdoff_req > 0) begin
        m_tready <= 1'b0;
        repeat (holdoff_req - 1) @(posedge clk_i);
        holdoff_req = 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Step through the idling phases as the byte count grows
  function automatic void set_idling();
    int phase;
    phase = (bytes_sent * 4) / ItemTarget;
    if (phase > 3) phase = 3;
    send_idle_pct  = (phase == 1) ? 46 : (phase == 3) ? 34 : 0;
    recv_stall_pct = (phase == 2) ? 46 : (phase == 3) ? 34 : 0;
  endfunction

  // Offer one byte, idling at random first, and hold it until accepted
  task automatic send_byte(input bit [7:0] b, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    sb.note_item(b, last);
    bytes_sent++;
  endtask

  task automatic send_image();
    set_idling();
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
    files_sent++;
  endtask

  // Write a little-endian value into the image, clipped at its end
  function automatic void put_le(int unsigned at, bit [31:0] v, int nbytes);
    for (int k = 0; k < nbytes; k++) begin
      if (at + k < img.size()) img[at + k] = v[8*k +: 8];
    end
  endfunction

  // Build a file image of the given kind
  function automatic void build_image(file_kind_e kind);
    int unsigned off, opt, nsec, tbl, tend, dend, len, ent, hit, at;
    bit [31:0]   ptr, size, tgt;
    img.delete();
    if (kind == FileNoise) begin
      len = $urandom_range(1, 100);
      repeat (len) img.push_back(8'($urandom));
      if ($urandom_range(1) == 1 && len >= 2) begin
        img[0] = CharM;
        img[1] = CharZ;
      end
      return;
    end

    // Lay out compact headers, section table, section data and overlay
    off  = ($urandom_range(1) == 0) ? HdrMinOff : $urandom_range(64, 72);
    opt  = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 4);
    nsec = (kind == FileGood || kind == FileWrapEnd) ? $urandom_range(1, 2) : 1;
    tbl  = off + PeFixedLen + opt;
    tend = tbl + nsec * 40;
    dend = tend + $urandom_range(1, 4);
    len  = dend + $urandom_range(1, 2);
    repeat (len) img.push_back(8'($urandom));
    img[0] = CharM;
    img[1] = CharZ;
    put_le(HdrPtrPos, off, 4);
    img[off]     = CharP;
    img[off + 1] = CharE;
    img[off + 2] = 8'h00;
    img[off + 3] = 8'h00;
    put_le(off + OffCntLo, nsec, 2);
    put_le(off + OffOptLo, opt, 2);

    // Fill the entries; unless the kind breaks them, one ends where the section data ends
    hit = $urandom_range(0, nsec - 1);
    for (int s = 0; s < nsec; s++) begin
      ent = tbl + s * 40;
      case (kind)
        FileWrapEnd: begin
          ptr  = $urandom | 32'h8000_0000;
          tgt  = (s == hit) ? dend : $urandom_range(tend, dend);
          size = tgt - ptr;
        end
        FileZeroEnd: begin
          ptr  = ($urandom_range(1) == 1) ? 32'd0 : 32'($urandom);
          size = 32'd0 - ptr;
        end
        FileEndPastLen: begin
          ptr  = $urandom_range(0, len);
          size = (s == hit) ? len + $urandom_range(0, 1000) - ptr : 0;
        end
        default: begin
          ptr  = $urandom_range(tend, dend - 1);
          size = (s == hit) ? dend - ptr : $urandom_range(0, dend - ptr);
        end
      endcase
      put_le(ent + RawSizeLo, size, 4);
      put_le(ent + RawSizeLo + 4, ptr, 4);
    end

    // Break the file as the kind asks
    case (kind)
      FileNoMz: begin
        at = $urandom_range(1);
        img[at] = img[at] ^ 8'($urandom_range(1, 255));
      end
      FileLowOff: put_le(HdrPtrPos, $urandom_range(0, 63), 4);
      FileFarOff: begin
        if ($urandom_range(1) == 1) put_le(HdrPtrPos, $urandom_range(len - 23, len + 200), 4);
        else put_le(HdrPtrPos, $urandom, 4);
      end
      FileNoSig: begin
        at = off + $urandom_range(3);
        img[at] = img[at] ^ 8'($urandom_range(1, 255));
      end
      FileNoSections: put_le(off + OffCntLo, 0, 2);
      FileTooMany: begin
        if ($urandom_range(1) == 1) put_le(off + OffCntLo, MaxSectionsDef + 1, 2);
        else put_le(off + OffCntLo, $urandom_range(MaxSectionsDef + 1, 65535), 2);
      end
      FileTruncated: begin
        len = $urandom_range(1, len - 1);
        img = img[0:len-1];
      end
      default: ;
    endcase
  endfunction

  // Mostly well-formed files, then truncations, noise and other broken variants
  function automatic file_kind_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 50) return FileGood;
    if (r < 56) return FileWrapEnd;
    if (r < 70) return FileTruncated;
    if (r < 85) return FileNoise;
    return file_kind_e'($urandom_range(FileNoMz, FileEndPastLen));
  endfunction

  initial begin
    sb = new(MaxSectionsDef);
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Short files: byte extremes and the too-short rule
    img = '{8'h00};
    send_image();
    img = '{8'hFF};
    send_image();
    img = '{CharM, CharZ};
    send_image();
    img.delete();
    repeat (20) img.push_back(8'($urandom));
    img[0] = CharM;
    img[1] = CharZ;
    send_image();

    // One file of every kind
    for (int k = FileGood; k <= FileNoise; k++) begin
      build_image(file_kind_e'(k));
      send_image();
    end

    // Hold results back while tiny files keep arriving
    holdoff_req = HoldCycles;
    repeat (16) begin
      img.delete();
      repeat ($urandom_range(1, 3)) img.push_back(8'($urandom));
      send_image();
    end

    // Top up with random files until the byte budget is spent
    while (bytes_sent < ItemTarget) begin
      build_image(pick_kind());
      send_image();
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.offset_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Streamed %0d files in %0d bytes, with idling on both sides and a held-off sink",
             files_sent, bytes_sent);
    $display("Results: ok %0d, no MZ %0d, bad header %0d, no PE %0d, bad table %0d, no overlay %0d",
             sb.status_hits[StOk], sb.status_hits[StNoMz], sb.status_hits[StBadHdr],
             sb.status_hits[StNoPe], sb.status_hits[StBadTable], sb.status_hits[StNoOverlay]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
